### rtl/core/bamr_pkg.sv
// Package: shared constants and types for the bridge converter readout.
`timescale 1ns / 1ps
package bamr_pkg;
  localparam int unsigned MaxSamplesDef = 16;
  localparam int unsigned PowerTicksDef = 64;
  localparam int unsigned BasePulses    = 25;
  localparam int unsigned SampleW       = 24;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 32;

  localparam logic [CfgIdxW-1:0] RegGainMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSampleCount = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTimeout     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSettle      = 2'd3;

  localparam logic [SampleW-1:0] SettleReset = 24'd400;

  typedef struct packed {
    logic              cmd;
    logic              data_level;
  } bamr_in_t;

  typedef struct packed {
    logic               clock_level;
    logic               done_res;
    logic               status;
    logic signed [23:0] median_value;
  } bamr_out_t;
endpackage

### rtl/core/bamr_if.sv
// Interfaces: valid/ready channels for input ticks and results.
`timescale 1ns / 1ps
interface bamr_in_if;
  logic              valid;
  logic              ready;
  bamr_pkg::bamr_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bamr_out_if;
  logic               valid;
  logic               ready;
  bamr_pkg::bamr_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/bridge_adc_readout_median.sv
// Top level: tick-driven readout of a two-wire 24-bit bridge converter with median.
`timescale 1ns / 1ps
// Each input transfer is one tick (half a serial clock period). Its result is registered
// and offered in the next cycle. The next tick is taken only when the output register is
// empty or is emptied in that cycle. The tick that completes the last sample starts an
// insertion sort in a single shared compare/move unit over the sample memory, during
// which no tick is taken. The median or the mean of the middle two (truncated toward
// zero) is then emitted as that tick's result.
module bridge_adc_readout_median #(
  parameter int unsigned MAX_SAMPLES = bamr_pkg::MaxSamplesDef,
  parameter int unsigned POWER_TICKS = bamr_pkg::PowerTicksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bamr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bamr_pkg::CfgDataW-1:0] cfg_wdata_i,
  bamr_in_if.sink                       in_if,
  bamr_out_if.source                    out_if
);
  import bamr_pkg::*;

  localparam int unsigned IdxW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_POWER  = 6'b000010,
    PH_SETTLE = 6'b000100,
    PH_WAIT   = 6'b001000,
    PH_HIGH   = 6'b010000,
    PH_LOW    = 6'b100000
  } phase_e;

  typedef enum logic [6:0] {
    S_OFF   = 7'b0000001,
    S_LOADX = 7'b0000010,
    S_RDJ   = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_INS   = 7'b0010000,
    S_RDM0  = 7'b0100000,
    S_RDM1  = 7'b1000000
  } sort_e;

  logic [1:0]  gain_q;
  logic [4:0]  scount_q;
  logic [31:0] timeout_q;
  logic [23:0] settle_q;

  phase_e      phase_q;
  logic [31:0] tick_q, elapsed_q;
  logic [4:0]  pulses_q;
  logic [23:0] shift_q;
  logic [CntW-1:0] sidx_q;
  logic        discard_q;

  sort_e       sst_q;
  logic [CntW-1:0] n_q, si_q, sj_q;
  logic signed [23:0] x_q, rd_q, m0_q;
  logic [23:0] mem [MAX_SAMPLES];

  logic        ovalid_q;
  bamr_out_t   out_q;

  logic [CntW-1:0] eff_n;
  always_comb begin
    if (scount_q == 5'd0) eff_n = CntW'(1);
    else if (32'(scount_q) > MAX_SAMPLES) eff_n = CntW'(MAX_SAMPLES);
    else eff_n = CntW'(scount_q);
  end

  logic busy;
  assign busy = (sst_q != S_OFF);
  assign in_if.ready = !busy && (!ovalid_q || out_if.ready);
  logic acc;
  assign acc = in_if.valid && in_if.ready;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = out_q;

  // Tick datapath
  logic        mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [23:0] mem_wd;
  logic [IdxW-1:0] mem_ra;

  logic        t_clk, t_done, t_stat, t_sort;
  phase_e      ph_d;
  logic [31:0] tick_d, el_d;
  logic [4:0]  pul_d;
  logic [23:0] sh_d;
  logic [CntW-1:0] sidx_d;
  logic        dis_d;
  logic        t_we;
  logic [CntW:0] sidx_inc;

  always_comb begin
    ph_d = phase_q; tick_d = tick_q; el_d = elapsed_q; pul_d = pulses_q;
    sh_d = shift_q; sidx_d = sidx_q; dis_d = discard_q;
    t_clk = 1'b0; t_done = 1'b0; t_stat = 1'b0; t_sort = 1'b0; t_we = 1'b0;
    sidx_inc = {1'b0, sidx_q} + 1'b1;
    if (in_if.data.cmd) begin
      ph_d = PH_POWER; tick_d = '0; el_d = '0; pul_d = '0; sh_d = '0;
      sidx_d = '0; dis_d = (gain_q != 2'd0); t_clk = 1'b1;
    end else begin
      if (phase_q != PH_IDLE && elapsed_q != 32'hFFFF_FFFF) el_d = elapsed_q + 1'b1;
      case (phase_q)
        PH_POWER: begin
          tick_d = tick_q + 1'b1;
          if (tick_d >= 32'(POWER_TICKS)) begin
            ph_d = PH_SETTLE; tick_d = '0;
          end else begin
            t_clk = 1'b1;
          end
        end
        PH_SETTLE: begin
          if (tick_q != 32'hFFFF_FFFF) tick_d = tick_q + 1'b1;
          if (tick_d >= 32'(settle_q)) ph_d = PH_WAIT;
        end
        PH_WAIT: begin
          if (!in_if.data.data_level) begin
            pul_d = 5'(BasePulses) + 5'(gain_q); sh_d = '0; ph_d = PH_HIGH; t_clk = 1'b1;
          end else if (timeout_q != 32'd0 && el_d >= timeout_q) begin
            ph_d = PH_IDLE; t_clk = 1'b1; t_done = 1'b1; t_stat = 1'b1;
          end
        end
        PH_HIGH: begin
          if (pulses_q > 5'd1 + 5'(gain_q)) sh_d = {shift_q[22:0], in_if.data.data_level};
          if (pulses_q != 5'd0) pul_d = pulses_q - 1'b1;
          if (pul_d == 5'd0) begin
            if (discard_q) begin
              dis_d = 1'b0;
            end else begin
              if (sidx_q < CntW'(MAX_SAMPLES)) t_we = 1'b1;
              if (sidx_q != {CntW{1'b1}}) sidx_d = sidx_inc[CntW-1:0];
            end
            if (sidx_d >= eff_n) begin
              ph_d = PH_IDLE; t_sort = 1'b1;
            end else begin
              ph_d = PH_WAIT;
            end
          end else begin
            ph_d = PH_LOW;
          end
        end
        PH_LOW: begin
          ph_d = PH_HIGH; t_clk = 1'b1;
        end
        default: begin
          ph_d = PH_IDLE; t_clk = 1'b1;
        end
      endcase
    end
  end

  // Sort sequencer: insertion sort over the sample memory, then the median read
  logic        s_we;
  logic [IdxW-1:0] s_wa;
  logic [23:0] s_wd;
  logic [IdxW-1:0] s_ra;
  sort_e       sst_d;
  logic [CntW-1:0] si_d, sj_d;
  logic [CntW-1:0] half, jm1;
  logic signed [24:0] msum;
  logic signed [24:0] mavg;
  logic        s_fin;

  assign half = n_q >> 1;
  assign jm1  = sj_q - 1'b1;
  assign msum = 25'(m0_q) + 25'(rd_q);
  assign mavg = (msum + 25'(msum[24])) >>> 1;

  always_comb begin
    sst_d = sst_q; si_d = si_q; sj_d = sj_q;
    s_we = 1'b0; s_wa = si_q[IdxW-1:0]; s_wd = x_q; s_ra = si_q[IdxW-1:0]; s_fin = 1'b0;
    case (sst_q)
      S_LOADX: begin
        if (si_q >= n_q) begin
          s_ra = half[IdxW-1:0];
          sst_d = n_q[0] ? S_RDM1 : S_RDM0;
          if (!n_q[0]) s_ra = IdxW'(half - 1'b1);
        end else begin
          s_ra = si_q[IdxW-1:0]; sj_d = si_q; sst_d = S_RDJ;
        end
      end
      S_RDJ: begin
        if (sj_q == '0) begin
          sst_d = S_INS;
        end else begin
          s_ra = jm1[IdxW-1:0]; sst_d = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_q > x_q) begin
          s_we = 1'b1; s_wa = sj_q[IdxW-1:0]; s_wd = rd_q;
          sj_d = jm1; sst_d = S_RDJ;
        end else begin
          sst_d = S_INS;
        end
      end
      S_INS: begin
        s_we = 1'b1; s_wa = sj_q[IdxW-1:0]; s_wd = x_q;
        si_d = si_q + 1'b1; sst_d = S_LOADX;
      end
      S_RDM0: begin
        s_ra = half[IdxW-1:0]; sst_d = S_RDM1; si_d = '0;
      end
      S_RDM1: begin
        s_fin = 1'b1; sst_d = S_OFF;
      end
      default: sst_d = S_OFF;
    endcase
  end

  assign mem_we = (acc && t_we) || s_we;
  assign mem_wa = s_we ? s_wa : sidx_q[IdxW-1:0];
  assign mem_wd = s_we ? s_wd : sh_d;
  assign mem_ra = s_ra;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sst_q == S_RDJ && sj_q == si_q) x_q <= rd_q;
    if (sst_q == S_RDM0) m0_q <= rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0; scount_q <= 5'd1; timeout_q <= '0; settle_q <= SettleReset;
      phase_q <= PH_IDLE; tick_q <= '0; elapsed_q <= '0; pulses_q <= '0;
      shift_q <= '0; sidx_q <= '0; discard_q <= 1'b0;
      sst_q <= S_OFF; n_q <= '0; si_q <= '0; sj_q <= '0;
      ovalid_q <= 1'b0; out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGainMode:    gain_q    <= cfg_wdata_i[1:0];
          RegSampleCount: scount_q  <= cfg_wdata_i[4:0];
          RegTimeout:     timeout_q <= cfg_wdata_i;
          RegSettle:      settle_q  <= cfg_wdata_i[23:0];
          default: ;
        endcase
      end
      if ((acc && !t_sort) || (busy && s_fin)) ovalid_q <= 1'b1;
      else if (out_if.ready) ovalid_q <= 1'b0;
      if (acc) begin
        phase_q <= ph_d; tick_q <= tick_d; elapsed_q <= el_d; pulses_q <= pul_d;
        shift_q <= sh_d; sidx_q <= sidx_d; discard_q <= dis_d;
        if (t_sort) begin
          sst_q <= S_LOADX; n_q <= eff_n; si_q <= CntW'(1);
        end else begin
          out_q <= '{clock_level: t_clk, done_res: t_done, status: t_stat,
                     median_value: '0};
        end
      end else if (busy) begin
        sst_q <= sst_d; si_q <= si_d; sj_q <= sj_d;
        if (s_fin) begin
          out_q <= '{clock_level: 1'b1, done_res: 1'b1, status: 1'b0,
                     median_value: n_q[0] ? rd_q : mavg[23:0]};
        end
      end
    end
  end
endmodule
